>>> src/pid_keyed_stack_table_defines.svh
// Assertion macros for the pid keyed stack table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PID_KEYED_STACK_TABLE_DEFINES_SVH
`define PID_KEYED_STACK_TABLE_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define PKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PKST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/pkst_pkg.sv
// Shared constants, codes and link types of the pid keyed stack table.
// No dependencies; compile first.
`default_nettype none

package pkst_pkg;

  localparam int ENTRIES  = 64;
  localparam int PID_W    = 16;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_CONSUME  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_CONSUMED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_INVALID   = 3'd5
  } status_t;

  // Token handed from cell to cell: one walks the row per pass.
  typedef struct packed {
    logic              tok;   // token present at this link
    logic              hit;   // search: key matched; claim: entry taken
    logic              free;  // search: an empty entry was passed
    logic [ADDR_W-1:0] data;  // address of the matching entry
  } link_t;

  // Request fields broadcast to every cell.
  typedef struct packed {
    logic              claim;    // second pass: fill the first empty entry
    logic              consume;  // consume request, else register
    logic [PID_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
  } bcast_t;

endpackage

`default_nettype wire

>>> src/pkst_in_if.sv
// Request channel of the pid keyed stack table: valid, ready, payload.
// Depends on pkst_pkg.
`default_nettype none

interface pkst_in_if import pkst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [PID_W-1:0]  pid;
  logic [ADDR_W-1:0] stack_address;

  modport source (output valid, output cmd, output pid, output stack_address, input ready);
  modport sink   (input valid, input cmd, input pid, input stack_address, output ready);
endinterface

`default_nettype wire

>>> src/pkst_out_if.sv
// Result channel of the pid keyed stack table: valid, ready, payload.
// Depends on pkst_pkg.
`default_nettype none

interface pkst_out_if import pkst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   stack_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output stack_out, output status, input ready);
  modport sink   (input valid, input stack_out, input status, output ready);
endinterface

`default_nettype wire

>>> src/pkst_cell.sv
// One table entry: id and address, plus the link register toward the next cell.
// Depends on pkst_pkg.
`default_nettype none

module pkst_cell import pkst_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire bcast_t ctl,
  input  wire link_t  link_in,
  output link_t       link_out
);

  logic [PID_W-1:0]  id_r, id_nxt;
  logic [ADDR_W-1:0] ent_addr_r, ent_addr_nxt;
  link_t             link_r, link_nxt;
  logic              match;
  logic              empty;

  assign match = (ctl.key != '0) && (id_r == ctl.key);
  assign empty = (id_r == '0);

  // Act on the passing token, then hand it on
  always_comb begin
    id_nxt       = id_r;
    ent_addr_nxt = ent_addr_r;
    link_nxt     = link_in;
    if (link_in.tok) begin
      if (ctl.claim) begin
        // take the request in the first empty entry along the row
        if (!link_in.hit && empty) begin
          id_nxt       = ctl.key;
          ent_addr_nxt = ctl.addr;
          link_nxt.hit = 1'b1;
        end
      end else begin
        link_nxt.hit  = link_in.hit | match;
        link_nxt.free = link_in.free | empty;
        if (match) begin
          link_nxt.data = ent_addr_r;
          if (ctl.consume) begin
            id_nxt = '0;
          end else begin
            ent_addr_nxt = ctl.addr;
          end
        end
      end
    end
  end

  // Hold id and link; empty the entry at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r   <= '0;
      link_r <= '0;
    end else begin
      id_r   <= id_nxt;
      link_r <= link_nxt;
    end
  end

  // Address store is defined only once written
  always_ff @(posedge clk) begin
    ent_addr_r <= ent_addr_nxt;
  end

  assign link_out = link_r;

endmodule

`default_nettype wire

>>> src/pid_keyed_stack_table.sv
// Top level of the pid keyed stack table: request sequencer and a row of entry cells.
// Depends on pkst_pkg, pkst_in_if, pkst_out_if, pkst_cell and the defines header.
//
//   port     dir   word fields
//   in_ch    sink  cmd, pid, stack_address
//   out_ch   src   stack_out, status
//
// A request word sends a token down the row of ENTRIES cells, one cell a cycle.
// Update, consume, not found and table full answer after the search pass;
// an insert needs a second pass to claim the first empty entry.
// Invalid register arguments skip the row and go straight to the result state.
// Reset empties every entry at once; no clearing pass.
// The next request word is taken while a result waits in the output register.
`default_nettype none
`include "pid_keyed_stack_table_defines.svh"

module pid_keyed_stack_table import pkst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  pkst_in_if.sink   in_ch,
  pkst_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CLAIM,
    S_DONE
  } state_t;

  state_t              state_r;
  cmd_t                req_cmd_r;
  logic [PID_W-1:0]    req_key_r;
  logic [ADDR_W-1:0]   req_addr_r;
  link_t               inj_r;
  link_t               inj_nxt;
  logic [ADDR_W-1:0]   res_addr_r;
  status_t             res_status_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_stack_r;
  status_t             out_status_r;

  link_t               links [ENTRIES+1];
  logic [ENTRIES:0]    tok_vec;
  link_t               chain_end;
  bcast_t              ctl;
  logic                accept;
  logic                bad_args;
  logic                out_load;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign bad_args    = (cmd_t'(in_ch.cmd) == CMD_REGISTER) &&
                       ((in_ch.pid == '0) || (in_ch.stack_address == '0));
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Broadcast the held request to every cell
  assign ctl.claim   = (state_r == S_CLAIM);
  assign ctl.consume = (req_cmd_r == CMD_CONSUME);
  assign ctl.key     = req_key_r;
  assign ctl.addr    = req_addr_r;

  // Build the row of cells
  assign links[0] = inj_r;
  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      pkst_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .link_in  (links[gi]),
        .link_out (links[gi+1])
      );
    end
    for (gi = 0; gi <= ENTRIES; gi++) begin : g_tok
      assign tok_vec[gi] = links[gi].tok;
    end
  endgenerate

  assign chain_end = links[ENTRIES];

  // Inject a token for a fresh request or to start the claim pass
  always_comb begin
    inj_nxt = '0;
    unique case (state_r)
      S_IDLE:   inj_nxt.tok = accept && !bad_args;
      S_SEARCH: inj_nxt.tok = chain_end.tok && (req_cmd_r == CMD_REGISTER) &&
                              !chain_end.hit && chain_end.free;
      default:  inj_nxt.tok = 1'b0;
    endcase
  end

  // Sequence one request: search pass, optional claim pass, result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      inj_r       <= inj_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_cmd_r  <= cmd_t'(in_ch.cmd);
            req_key_r  <= in_ch.pid;
            req_addr_r <= in_ch.stack_address;
            if (bad_args) begin
              res_addr_r   <= '0;
              res_status_r <= ST_INVALID;
              state_r      <= S_DONE;
            end else begin
              state_r   <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (chain_end.tok) begin
            if (req_cmd_r == CMD_CONSUME) begin
              res_addr_r   <= chain_end.hit ? chain_end.data : '0;
              res_status_r <= chain_end.hit ? ST_CONSUMED : ST_NOT_FOUND;
              state_r      <= S_DONE;
            end else if (chain_end.hit) begin
              res_addr_r   <= '0;
              res_status_r <= ST_UPDATED;
              state_r      <= S_DONE;
            end else if (chain_end.free) begin
              state_r   <= S_CLAIM;
            end else begin
              res_addr_r   <= '0;
              res_status_r <= ST_FULL;
              state_r      <= S_DONE;
            end
          end
        end
        S_CLAIM: begin
          if (chain_end.tok) begin
            res_addr_r   <= '0;
            res_status_r <= ST_INSERTED;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_stack_r  <= res_addr_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.stack_out = out_stack_r;
  assign out_ch.status    = out_status_r;

  // At most one token walks the row
  `PKST_ASSERT(a_one_token, $onehot0(tok_vec), "more than one token in the cell row")
  // A new word never enters while a token is still in the row
  `PKST_ASSERT_IMPL(a_accept_quiet, accept, tok_vec == '0, "word accepted with token in flight")
  // The row only returns a token during a pass
  `PKST_ASSERT_IMPL(a_end_in_pass, chain_end.tok,
                    (state_r == S_SEARCH) || (state_r == S_CLAIM), "token left row outside a pass")
  // A claim pass always finds the empty entry seen by the search
  `PKST_ASSERT_IMPL(a_claim_taken, (state_r == S_CLAIM) && chain_end.tok, chain_end.hit,
                    "claim pass found no empty entry")

endmodule

`default_nettype wire

>>> bench/tb_pid_keyed_stack_table.sv
`timescale 1ns / 1ps
// Self-checking bench for the pid keyed stack table: register and consume words in, one reply out.
// Depends on pkst_pkg, pkst_in_if, pkst_out_if and the pid_keyed_stack_table top level.

module tb_pid_keyed_stack_table;
  import pkst_pkg::*;

  localparam int RANDOM_ITEMS = 930;
  localparam int POOL_SIZE    = 80;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 2 * ENTRIES + 8;

  typedef struct {
    logic [ADDR_W-1:0] stack_out;
    status_t           status;
  } reply_t;

  // Mirror of the table contents plus the replies still owed by the block.
  class pid_table_scoreboard;
    logic [PID_W-1:0]  slot_pid[ENTRIES];
    logic [ADDR_W-1:0] slot_addr[ENTRIES];
    reply_t            owed_replies[$];
    int                errors;
    int                requests;
    int                status_seen[6];

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_pid[i]  = '0;
        slot_addr[i] = '0;
      end
      errors   = 0;
      requests = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endfunction

    function int owed();
      return owed_replies.size();
    endfunction

    // Apply one accepted request to the mirror and queue the reply it earns.
    function void note_request(cmd_t op, logic [PID_W-1:0] pid, logic [ADDR_W-1:0] addr);
      reply_t r;
      int     hit;
      int     slot;
      r.stack_out = '0;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (pid != '0 && slot_pid[i] == pid && hit < 0) hit = i;
        if (slot_pid[i] == '0 && slot < 0) slot = i;
      end
      if (op == CMD_REGISTER) begin
        if (pid == '0 || addr == '0) begin
          r.status = ST_INVALID;
        end else if (hit >= 0) begin
          slot_addr[hit] = addr;
          r.status = ST_UPDATED;
        end else if (slot >= 0) begin
          slot_pid[slot]  = pid;
          slot_addr[slot] = addr;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        if (hit >= 0) begin
          r.stack_out    = slot_addr[hit];
          slot_pid[hit]  = '0;
          slot_addr[hit] = '0;
          r.status = ST_CONSUMED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      requests++;
      owed_replies.push_back(r);
    endfunction

    // Compare a delivered reply with the oldest one owed.
    function void check_result(logic [ADDR_W-1:0] got_addr, logic [STATUS_W-1:0] got_status);
      reply_t r;
      if (owed_replies.size() == 0) begin
        report($sformatf("unexpected reply stack_out=%h status=%0d", got_addr, got_status));
        return;
      end
      r = owed_replies.pop_front();
      if (got_status !== r.status)
        report($sformatf("status %0d, want %0d", got_status, r.status));
      if (got_addr !== r.stack_out)
        report($sformatf("stack_out %h, want %h (status %0d)", got_addr, r.stack_out, r.status));
      if (r.status <= ST_INVALID) status_seen[r.status]++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic quiet;
  int   cycle_count;
  logic [PID_W-1:0] pid_pool[POOL_SIZE];
  pid_table_scoreboard sb;

  pkst_in_if  in_ch();
  pkst_out_if out_ch();

  pid_keyed_stack_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles for the run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d replies still owed", cycle_count, sb.owed());
    $display("pid_keyed_stack_table regression: fail");
    $finish;
  end

  // Drop ready at random, except inside the quiet stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  // Check every reply word at the edge that moves it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.stack_out, out_ch.status);
  end

  // Offer one request word from a falling edge and hold it until taken.
  task automatic send_request(input cmd_t op, input logic [PID_W-1:0] pid,
                              input logic [ADDR_W-1:0] addr);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.cmd           = op;
    in_ch.pid           = pid;
    in_ch.stack_address = addr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, pid, addr);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed reply has come back.
  task automatic wait_for_drain();
    in_ch.valid = 1'b0;
    while (sb.owed() != 0) @(negedge clk);
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 8) return '1;
    if (roll < 22) return PID_W'($urandom_range(0, 65535));
    return pid_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 7) return '1;
    return ADDR_W'($urandom());
  endfunction

  // Corner cases: field extremes, invalid arguments, misses, reuse of a freed entry.
  task automatic run_directed();
    send_request(CMD_REGISTER, 16'hFFFF, 32'hFFFF_FFFF);  // insert at entry 0
    send_request(CMD_REGISTER, 16'hFFFF, 32'h0000_0001);  // update in place
    send_request(CMD_REGISTER, 16'h0000, 32'h0000_0005);  // zero pid
    send_request(CMD_REGISTER, 16'h0007, 32'h0000_0000);  // zero address
    send_request(CMD_REGISTER, 16'h0000, 32'h0000_0000);
    send_request(CMD_CONSUME,  16'h0000, 32'hFFFF_FFFF);  // empty entries never match
    send_request(CMD_CONSUME,  16'hFFFF, 32'h0000_0000);  // returns the updated address
    send_request(CMD_CONSUME,  16'hFFFF, 32'h0000_0000);  // now a miss
    send_request(CMD_REGISTER, 16'h0001, 32'hA5A5_5A5A);
    send_request(CMD_REGISTER, 16'h0002, 32'h5A5A_A5A5);
    send_request(CMD_REGISTER, 16'h8000, 32'h8000_0000);
    wait_for_drain();
    send_request(CMD_CONSUME,  16'h0001, 32'h0);          // frees entry 0
    send_request(CMD_REGISTER, 16'h0003, 32'h1234_5678);  // refills entry 0
    send_request(CMD_CONSUME,  16'h0003, 32'h0);          // entry 0 empty again
    send_request(CMD_REGISTER, 16'h0002, 32'hCAFE_F00D);  // update above an empty entry
    send_request(CMD_CONSUME,  16'h0002, 32'h0);
    send_request(CMD_CONSUME,  16'h8000, 32'h0);
    send_request(CMD_CONSUME,  16'h1234, 32'h0);
    wait_for_drain();
  endtask

  initial begin
    int random_sent;
    int segment;
    int seg_len;
    int reg_pct;
    cmd_t op;
    rst_n               = 1'b0;
    quiet               = 1'b0;
    cycle_count         = 0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_REGISTER;
    in_ch.pid           = '0;
    in_ch.stack_address = '0;
    sb = new();
    for (int i = 0; i < POOL_SIZE; i++) pid_pool[i] = PID_W'($urandom_range(1, 65535));
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();

    // Alternate fill-heavy, mixed and drain-heavy segments; the first one overfills the table.
    random_sent = 0;
    segment     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: reg_pct = 90;
        1: reg_pct = 50;
        default: reg_pct = 20;
      endcase
      if (segment == 0) begin
        seg_len = 120;
        reg_pct = 95;
      end
      for (int k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++) begin
        quiet = (random_sent >= 200 && random_sent < 400);
        op = ($urandom_range(0, 99) < reg_pct) ? CMD_REGISTER : CMD_CONSUME;
        send_request(op, pick_pid(), pick_addr());
        random_sent++;
      end
      quiet = 1'b0;
      wait_for_drain();
      segment++;
    end

    // Let any stray reply surface before the verdict.
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d requests over %0d segments; %0d replies still owed", sb.requests,
             segment, sb.owed());
    $display("replies: %0d updated, %0d inserted, %0d consumed, %0d not found, %0d full, %0d invalid",
             sb.status_seen[ST_UPDATED], sb.status_seen[ST_INSERTED], sb.status_seen[ST_CONSUMED],
             sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL], sb.status_seen[ST_INVALID]);
    if (sb.owed() != 0) sb.report("replies never delivered");
    if (sb.errors == 0) begin
      $display("pid_keyed_stack_table regression: pass");
    end else begin
      $display("pid_keyed_stack_table regression: fail");
    end
    $finish;
  end

endmodule
